[sv/fixed_point_notch_biquad_unit_macros.svh]
// Assertion macros shared by the notch biquad RTL.
`ifndef FIXED_POINT_NOTCH_BIQUAD_UNIT_MACROS_SVH
`define FIXED_POINT_NOTCH_BIQUAD_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FNB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fnb assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FNB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fnb assertion failed");

`endif

[sv/fnb_pkg.sv]
// Types and constants of the notch biquad.
package fnb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED_COEF_0 = 3'd0,
    REG_FEED_COEF_1 = 3'd1,
    REG_FEED_COEF_2 = 3'd2,
    REG_BACK_COEF_1 = 3'd3,
    REG_BACK_COEF_2 = 3'd4
  } cfg_reg_t;

  localparam sample_t SAMPLE_MAX = 16'sd32767;
  localparam sample_t SAMPLE_MIN = -16'sd32768;

  localparam coef_t FEED_COEF_0_RESET = 16'sd16384;

endpackage

[sv/fnb_ifs.sv]
// Handshake interfaces for the sample and configuration channels.
interface fnb_in_if;
  logic             valid;
  logic             ready;
  fnb_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface fnb_out_if;
  logic             valid;
  logic             ready;
  fnb_pkg::sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface fnb_cfg_if;
  logic              valid;
  logic              ready;
  fnb_pkg::cfg_idx_t index;
  fnb_pkg::coef_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/fixed_point_notch_biquad_unit.sv]
// Direct Form I notch biquad on signed 16-bit samples, Q14 coefficients.
//
// Channels: raw carries one sample_in per beat, filtered returns one
// sample_out per accepted sample in the same order, cfg writes one of the
// five coefficient registers per beat (index 0 to 4, other indexes ignored).
// The cfg channel is always ready; write it only while the filter is idle.
//
// Timing: an accepted sample is registered in the input register, then filtered
// into the output register once that is empty or filtered is ready, and shown
// on filtered from then on. Throughput: one sample per cycle while filtered is
// ready. The feedback path from the past outputs through two parallel 16 by 16
// multipliers, the five-term sum and the saturation back into the history
// registers sets the clock period.
//
// Reset: feed_coef_0 becomes 16384 (unity gain), the other coefficients and
// the four history registers become zero and both stages empty.
// Stall: a result held on filtered stays stable; one more sample is taken
// into the input register, after which raw drops ready until filtered moves.
module fixed_point_notch_biquad_unit #(
  parameter int COEF_FRAC_BITS = 14
) (
  input logic       clk,
  input logic       rst,
  fnb_in_if.sink    raw,
  fnb_out_if.source filtered,
  fnb_cfg_if.sink   cfg
);
  import fnb_pkg::*;

  `include "fixed_point_notch_biquad_unit_macros.svh"

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W  = PROD_W - COEF_FRAC_BITS + 3;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  coef_t   feed_coef_0, feed_coef_1, feed_coef_2, back_coef_1, back_coef_2;
  sample_t past_in_1, past_in_2, past_out_1, past_out_2;

  logic    in_valid;
  sample_t in_sample;
  logic    out_valid;
  sample_t out_sample;

  logic advance;
  logic raw_accept;

  logic signed [PROD_W-1:0] prod_0, prod_1, prod_2, prod_3, prod_4;
  logic signed [ACC_W-1:0]  acc;
  sample_t                  result_next;

  assign advance    = in_valid && (!out_valid || filtered.ready);
  assign raw.ready  = !in_valid || advance;
  assign raw_accept = raw.valid && raw.ready;
  assign cfg.ready  = 1'b1;

  assign filtered.valid      = out_valid;
  assign filtered.sample_out = out_sample;

  always_comb begin
    prod_0 = PROD_W'(feed_coef_0) * PROD_W'(in_sample);
    prod_1 = PROD_W'(feed_coef_1) * PROD_W'(past_in_1);
    prod_2 = PROD_W'(feed_coef_2) * PROD_W'(past_in_2);
    prod_3 = PROD_W'(back_coef_1) * PROD_W'(past_out_1);
    prod_4 = PROD_W'(back_coef_2) * PROD_W'(past_out_2);
    acc = ACC_W'(prod_0 >>> COEF_FRAC_BITS) + ACC_W'(prod_1 >>> COEF_FRAC_BITS)
        + ACC_W'(prod_2 >>> COEF_FRAC_BITS) - ACC_W'(prod_3 >>> COEF_FRAC_BITS)
        - ACC_W'(prod_4 >>> COEF_FRAC_BITS);
    if (acc > SAT_HI) begin
      result_next = SAMPLE_MAX;
    end else if (acc < SAT_LO) begin
      result_next = SAMPLE_MIN;
    end else begin
      result_next = acc[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_coef_0 <= FEED_COEF_0_RESET;
      feed_coef_1 <= '0;
      feed_coef_2 <= '0;
      back_coef_1 <= '0;
      back_coef_2 <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FEED_COEF_0: feed_coef_0 <= cfg.data;
        REG_FEED_COEF_1: feed_coef_1 <= cfg.data;
        REG_FEED_COEF_2: feed_coef_2 <= cfg.data;
        REG_BACK_COEF_1: back_coef_1 <= cfg.data;
        REG_BACK_COEF_2: back_coef_2 <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      past_in_1  <= '0;
      past_in_2  <= '0;
      past_out_1 <= '0;
      past_out_2 <= '0;
    end else begin
      if (raw.ready) begin
        in_valid <= raw.valid;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        past_in_1  <= in_sample;
        past_in_2  <= past_in_1;
        past_out_1 <= result_next;
        past_out_2 <= past_out_1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (raw_accept) begin
      in_sample <= raw.sample_in;
    end
    if (advance) begin
      out_sample <= result_next;
    end
  end

  `FNB_ASSERT_SAME(a_stall_blocks_input, clk, rst, in_valid && out_valid && !filtered.ready, !raw.ready)
  `FNB_ASSERT_NEXT(a_accept_fills_input, clk, rst, raw_accept, in_valid)
  `FNB_ASSERT_NEXT(a_advance_shows_result, clk, rst, advance, out_valid && out_sample == past_out_1)
  `FNB_ASSERT_NEXT(a_history_shifts, clk, rst, advance, past_in_1 == $past(in_sample) && past_in_2 == $past(past_in_1))

endmodule
